### src/tvu_pkg.sv
package tvu_pkg;

  localparam int LIMB_W = 32;
  localparam int OPA_W  = 256;
  localparam int OPB_W  = 128;
  localparam int ACC_W  = 288;

  localparam logic [15:0] ONE_Q14 = 16'd16384;
  localparam logic [14:0] SEARCH_HI = 15'd16384;

  localparam logic [4:0] STEP_D   = 5'd1;
  localparam logic [4:0] STEP_E   = 5'd15;
  localparam logic [4:0] STEP_S   = 5'd23;
  localparam logic [4:0] STEP_L   = 5'd24;
  localparam logic [4:0] STEP_RHS = 5'd25;

  typedef enum logic [4:0] {
    SRC_S1, SRC_T1, SRC_S2, SRC_T2,
    SRC_E1X, SRC_E1Y, SRC_E1Z, SRC_E2X, SRC_E2Y, SRC_E2Z,
    SRC_D, SRC_TP1, SRC_TP2, SRC_BP1, SRC_BP2,
    SRC_EX, SRC_EY, SRC_EZ, SRC_V0, SRC_V1, SRC_V2,
    SRC_VSEL, SRC_S, SRC_KK
  } src_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_D, DST_TP1, DST_TP2, DST_BP1, DST_BP2,
    DST_EX, DST_EY, DST_EZ, DST_V0, DST_V1, DST_V2, DST_S, DST_L
  } dst_t;

  typedef struct packed {
    src_t a;
    src_t b;
    logic neg;
    logic clr;
    dst_t dst;
  } uop_t;

  typedef struct packed {
    logic       store_corner;
    logic       corner_idx;
    logic       start;
    logic       load;
    logic       mul;
    logic [2:0] li;
    logic [1:0] lj;
    logic       store;
    logic       search_init;
    logic       kk;
    logic       cmp;
    logic       res;
    logic [1:0] comp;
    logic       out_load;
    logic       out_degen;
    uop_t       op;
  } tvu_cmd_t;

  typedef struct packed {
    logic acc_zero;
    logic exy_zero;
    logic search_done;
  } tvu_stat_t;

  // micro program: a*b accumulated into acc, stored to dst on the last term
  function automatic uop_t uop(input logic [4:0] step);
    uop_t u;
    unique case (step)
      5'd0:  u = '{SRC_S1,  SRC_T2,  1'b0, 1'b1, DST_NONE};
      5'd1:  u = '{SRC_S2,  SRC_T1,  1'b1, 1'b0, DST_D};
      5'd2:  u = '{SRC_E1Y, SRC_T2,  1'b0, 1'b1, DST_NONE};
      5'd3:  u = '{SRC_E2Y, SRC_T1,  1'b1, 1'b0, DST_TP1};
      5'd4:  u = '{SRC_E1Z, SRC_T2,  1'b0, 1'b1, DST_NONE};
      5'd5:  u = '{SRC_E2Z, SRC_T1,  1'b1, 1'b0, DST_TP2};
      5'd6:  u = '{SRC_E2Y, SRC_S1,  1'b0, 1'b1, DST_NONE};
      5'd7:  u = '{SRC_E1Y, SRC_S2,  1'b1, 1'b0, DST_BP1};
      5'd8:  u = '{SRC_E2Z, SRC_S1,  1'b0, 1'b1, DST_NONE};
      5'd9:  u = '{SRC_E1Z, SRC_S2,  1'b1, 1'b0, DST_BP2};
      5'd10: u = '{SRC_E1Y, SRC_E2Z, 1'b0, 1'b1, DST_NONE};
      5'd11: u = '{SRC_E1Z, SRC_E2Y, 1'b1, 1'b0, DST_EX};
      5'd12: u = '{SRC_E1Z, SRC_E2X, 1'b0, 1'b1, DST_NONE};
      5'd13: u = '{SRC_E1X, SRC_E2Z, 1'b1, 1'b0, DST_EY};
      5'd14: u = '{SRC_E1X, SRC_E2Y, 1'b0, 1'b1, DST_NONE};
      5'd15: u = '{SRC_E1Y, SRC_E2X, 1'b1, 1'b0, DST_EZ};
      5'd16: u = '{SRC_BP1, SRC_EZ,  1'b0, 1'b1, DST_NONE};
      5'd17: u = '{SRC_BP2, SRC_EY,  1'b1, 1'b0, DST_V0};
      5'd18: u = '{SRC_TP2, SRC_EY,  1'b0, 1'b1, DST_NONE};
      5'd19: u = '{SRC_TP1, SRC_EZ,  1'b1, 1'b0, DST_V1};
      5'd20: u = '{SRC_D,   SRC_EX,  1'b0, 1'b1, DST_V2};
      5'd21: u = '{SRC_V0,  SRC_V0,  1'b0, 1'b1, DST_NONE};
      5'd22: u = '{SRC_V1,  SRC_V1,  1'b0, 1'b0, DST_NONE};
      5'd23: u = '{SRC_V2,  SRC_V2,  1'b0, 1'b0, DST_S};
      5'd24: u = '{SRC_VSEL, SRC_VSEL, 1'b0, 1'b1, DST_L};
      default: u = '{SRC_S, SRC_KK, 1'b0, 1'b1, DST_NONE};
    endcase
    return u;
  endfunction

  function automatic logic [3:0] limbs(input src_t s);
    logic [3:0] n;
    unique case (s)
      SRC_S1, SRC_T1, SRC_S2, SRC_T2, SRC_KK: n = 4'd1;
      SRC_EX, SRC_EY, SRC_EZ:                 n = 4'd3;
      SRC_V0, SRC_V1, SRC_V2, SRC_VSEL:       n = 4'd4;
      SRC_S:                                  n = 4'd8;
      default:                                n = 4'd2;
    endcase
    return n;
  endfunction

endpackage

### src/triangle_tangent_vector_unit.sv
// channel | dir | tdata (low bit up)                             | tuser
// in      | in  | pos_x 32, pos_y 32, pos_z 32, tex_s 24, tex_t 24 | first_corner
// out     | out | tangent_x 16, tangent_y 16, tangent_z 16         | degenerate
// first and second corner items are only stored; the unit stays ready for the next corner
// third corner starts a run on the shared 32x32 multiplier,
// mostly the three binary square root searches; degenerate triangles end early
// rst_n clears the corner count and the output valid
// a finished result waits in the output register; a new run waits only to load it
module triangle_tangent_vector_unit import tvu_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [143:0] in_tdata,  // pos_x, pos_y, pos_z, tex_s, tex_t
  input  logic         in_tuser,  // first_corner
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata, // tangent_x, tangent_y, tangent_z
  output logic         out_tuser  // degenerate
);

  tvu_cmd_t  cmd;
  tvu_stat_t stat;
  logic [15:0] tx, ty, tz;

  tvu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_first   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tvu_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .pos_x      (in_tdata[31:0]),
    .pos_y      (in_tdata[63:32]),
    .pos_z      (in_tdata[95:64]),
    .tex_s      (in_tdata[119:96]),
    .tex_t      (in_tdata[143:120]),
    .stat       (stat),
    .tangent_x  (tx),
    .tangent_y  (ty),
    .tangent_z  (tz),
    .degenerate (out_tuser)
  );

  assign out_tdata = {tz, ty, tx};

endmodule

### src/tvu_ctrl.sv
module tvu_ctrl import tvu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_first,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  tvu_stat_t stat,
  output tvu_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MULT, S_DRAIN, S_STORE, S_KK, S_CMP, S_RES, S_FIN
  } state_t;

  state_t     state_r, state_nxt;
  logic [4:0] step_r, step_nxt;
  logic [2:0] li_r, li_nxt;
  logic [1:0] lj_r, lj_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       deg_r, deg_nxt;
  logic       out_vld_r, out_vld_nxt;
  logic [1:0] idx;
  logic       acc_in;
  uop_t       op;
  logic [3:0] na, nb;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign acc_in     = in_tvalid && in_tready;
  assign op         = uop(step_r);
  assign na         = limbs(op.a);
  assign nb         = limbs(op.b);

  always_comb begin
    idx = in_first ? 2'd0 : cnt_r;
    if (idx == 2'd3) begin
      idx = 2'd0;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    li_nxt      = li_r;
    lj_nxt      = lj_r;
    comp_nxt    = comp_r;
    cnt_nxt     = cnt_r;
    deg_nxt     = deg_r;
    out_vld_nxt = out_vld_r;
    cmd         = '0;
    cmd.op      = op;
    cmd.li      = li_r;
    cmd.lj      = lj_r;
    cmd.comp    = comp_r;
    cmd.corner_idx = idx[0];
    cmd.out_degen  = deg_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (acc_in) begin
          if (idx == 2'd2) begin
            cmd.start = 1'b1;
            cnt_nxt   = 2'd0;
            step_nxt  = 5'd0;
            comp_nxt  = 2'd0;
            deg_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            cmd.store_corner = 1'b1;
            cnt_nxt = idx + 2'd1;
          end
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        li_nxt    = '0;
        lj_nxt    = '0;
        state_nxt = S_MULT;
      end
      S_MULT: begin
        cmd.mul = 1'b1;
        if (lj_r == 2'(nb - 4'd1)) begin
          lj_nxt = '0;
          if (li_r == 3'(na - 4'd1)) begin
            state_nxt = S_DRAIN;
          end else begin
            li_nxt = li_r + 3'd1;
          end
        end else begin
          lj_nxt = lj_r + 2'd1;
        end
      end
      S_DRAIN: state_nxt = S_STORE;
      S_STORE: begin
        cmd.store = 1'b1;
        priority if ((step_r == STEP_D || step_r == STEP_S) && stat.acc_zero) begin
          deg_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (step_r == STEP_E && stat.acc_zero && stat.exy_zero) begin
          deg_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (step_r == STEP_L) begin
          cmd.search_init = 1'b1;
          state_nxt = S_KK;
        end else if (step_r == STEP_RHS) begin
          state_nxt = S_CMP;
        end else begin
          step_nxt  = step_r + 5'd1;
          state_nxt = S_LOAD;
        end
      end
      S_KK: begin
        if (stat.search_done) begin
          state_nxt = S_RES;
        end else begin
          cmd.kk    = 1'b1;
          step_nxt  = STEP_RHS;
          state_nxt = S_LOAD;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_KK;
      end
      S_RES: begin
        cmd.res = 1'b1;
        if (comp_r == 2'd2) begin
          state_nxt = S_FIN;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          step_nxt  = STEP_L;
          state_nxt = S_LOAD;
        end
      end
      S_FIN: begin
        if (!out_vld_r || out_tready) begin
          cmd.out_load = 1'b1;
          out_vld_nxt  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= '0;
      li_r      <= '0;
      lj_r      <= '0;
      comp_r    <= '0;
      cnt_r     <= '0;
      deg_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      li_r      <= li_nxt;
      lj_r      <= lj_nxt;
      comp_r    <= comp_nxt;
      cnt_r     <= cnt_nxt;
      deg_r     <= deg_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

### src/tvu_dpath.sv
module tvu_dpath import tvu_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  tvu_cmd_t           cmd,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [23:0] tex_s,
  input  logic signed [23:0] tex_t,
  output tvu_stat_t          stat,
  output logic        [15:0] tangent_x,
  output logic        [15:0] tangent_y,
  output logic        [15:0] tangent_z,
  output logic               degenerate
);

  logic signed [31:0]  hp_r [6];
  logic signed [23:0]  ht_r [4];
  logic signed [24:0]  s1_r, t1_r, s2_r, t2_r;
  logic signed [32:0]  e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic signed [50:0]  d_r;
  logic signed [58:0]  tp1_r, tp2_r, bp1_r, bp2_r;
  logic signed [66:0]  ex_r, ey_r, ez_r;
  logic signed [126:0] v0_r, v1_r, v2_r;
  logic signed [OPA_W-1:0] s_r;
  logic [OPA_W-1:0]    l_r;
  logic [OPA_W-1:0]    opa_r;
  logic [OPB_W-1:0]    opb_r;
  logic                sign_r;
  logic [2*LIMB_W-1:0] pp_r;
  logic [3:0]          off_r;
  logic                pp_vld_r;
  logic [ACC_W-1:0]    acc_r;
  logic [14:0]         lo_r, hi_r;
  logic [29:0]         kk_r;
  logic [15:0]         rx_r, ry_r, rz_r;
  logic [15:0]         tx_r, ty_r, tz_r;
  logic                deg_r;

  logic signed [OPA_W-1:0] a_val, b_val, a_mag, b_mag;
  logic [ACC_W-1:0]    sh;
  logic [15:0]         mid_sum;
  logic [14:0]         mid, kodd;
  logic                le, vneg;
  logic [15:0]         res;

  function automatic logic signed [OPA_W-1:0] pick(input src_t s);
    logic signed [OPA_W-1:0] v;
    unique case (s)
      SRC_S1:  v = OPA_W'(s1_r);
      SRC_T1:  v = OPA_W'(t1_r);
      SRC_S2:  v = OPA_W'(s2_r);
      SRC_T2:  v = OPA_W'(t2_r);
      SRC_E1X: v = OPA_W'(e1x_r);
      SRC_E1Y: v = OPA_W'(e1y_r);
      SRC_E1Z: v = OPA_W'(e1z_r);
      SRC_E2X: v = OPA_W'(e2x_r);
      SRC_E2Y: v = OPA_W'(e2y_r);
      SRC_E2Z: v = OPA_W'(e2z_r);
      SRC_D:   v = OPA_W'(d_r);
      SRC_TP1: v = OPA_W'(tp1_r);
      SRC_TP2: v = OPA_W'(tp2_r);
      SRC_BP1: v = OPA_W'(bp1_r);
      SRC_BP2: v = OPA_W'(bp2_r);
      SRC_EX:  v = OPA_W'(ex_r);
      SRC_EY:  v = OPA_W'(ey_r);
      SRC_EZ:  v = OPA_W'(ez_r);
      SRC_V0:  v = OPA_W'(v0_r);
      SRC_V1:  v = OPA_W'(v1_r);
      SRC_V2:  v = OPA_W'(v2_r);
      SRC_VSEL: begin
        unique case (cmd.comp)
          2'd0:    v = OPA_W'(v0_r);
          2'd1:    v = OPA_W'(v1_r);
          default: v = OPA_W'(v2_r);
        endcase
      end
      SRC_S:   v = s_r;
      default: v = signed'(OPA_W'(kk_r));
    endcase
    return v;
  endfunction

  always_comb begin
    a_val   = pick(cmd.op.a);
    b_val   = pick(cmd.op.b);
    a_mag   = a_val[OPA_W-1] ? -a_val : a_val;
    b_mag   = b_val[OPA_W-1] ? -b_val : b_val;
    sh      = ACC_W'(pp_r) << {off_r, 5'b0};
    mid_sum = 16'(lo_r) + 16'(hi_r) + 16'd1;
    mid     = mid_sum[15:1];
    kodd    = 15'({mid, 1'b0} - 16'd1);
    le      = acc_r <= {2'b00, l_r, 30'b0};
    unique case (cmd.comp)
      2'd0:    vneg = v0_r[126];
      2'd1:    vneg = v1_r[126];
      default: vneg = v2_r[126];
    endcase
    res = vneg ? 16'(16'd0 - 16'(lo_r)) : 16'(lo_r);
  end

  assign stat.acc_zero    = (acc_r == '0);
  assign stat.exy_zero    = (ex_r == '0) && (ey_r == '0);
  assign stat.search_done = (lo_r >= hi_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_vld_r <= 1'b0;
    end else begin
      pp_vld_r <= cmd.mul;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_corner) begin
      if (cmd.corner_idx) begin
        hp_r[3] <= pos_x;
        hp_r[4] <= pos_y;
        hp_r[5] <= pos_z;
        ht_r[2] <= tex_s;
        ht_r[3] <= tex_t;
      end else begin
        hp_r[0] <= pos_x;
        hp_r[1] <= pos_y;
        hp_r[2] <= pos_z;
        ht_r[0] <= tex_s;
        ht_r[1] <= tex_t;
      end
    end
    if (cmd.start) begin
      e1x_r <= 33'(hp_r[0]) - 33'(pos_x);
      e1y_r <= 33'(hp_r[1]) - 33'(pos_y);
      e1z_r <= 33'(hp_r[2]) - 33'(pos_z);
      e2x_r <= 33'(hp_r[3]) - 33'(pos_x);
      e2y_r <= 33'(hp_r[4]) - 33'(pos_y);
      e2z_r <= 33'(hp_r[5]) - 33'(pos_z);
      s1_r  <= 25'(ht_r[0]) - 25'(tex_s);
      t1_r  <= 25'(ht_r[1]) - 25'(tex_t);
      s2_r  <= 25'(ht_r[2]) - 25'(tex_s);
      t2_r  <= 25'(ht_r[3]) - 25'(tex_t);
    end
    if (cmd.load) begin
      opa_r  <= a_mag;
      opb_r  <= b_mag[OPB_W-1:0];
      sign_r <= a_val[OPA_W-1] ^ b_val[OPA_W-1] ^ cmd.op.neg;
    end
    if (cmd.mul) begin
      pp_r  <= opa_r[{cmd.li, 5'b0} +: LIMB_W] * opb_r[{cmd.lj, 5'b0} +: LIMB_W];
      off_r <= 4'(cmd.li) + 4'(cmd.lj);
    end
    if (cmd.load && cmd.op.clr) begin
      acc_r <= '0;
    end else if (pp_vld_r) begin
      acc_r <= sign_r ? acc_r - sh : acc_r + sh;
    end
    if (cmd.store) begin
      unique case (cmd.op.dst)
        DST_D:   d_r   <= acc_r[50:0];
        DST_TP1: tp1_r <= acc_r[58:0];
        DST_TP2: tp2_r <= acc_r[58:0];
        DST_BP1: bp1_r <= acc_r[58:0];
        DST_BP2: bp2_r <= acc_r[58:0];
        DST_EX:  ex_r  <= acc_r[66:0];
        DST_EY:  ey_r  <= acc_r[66:0];
        DST_EZ:  ez_r  <= acc_r[66:0];
        DST_V0:  v0_r  <= acc_r[126:0];
        DST_V1:  v1_r  <= acc_r[126:0];
        DST_V2:  v2_r  <= acc_r[126:0];
        DST_S:   s_r   <= acc_r[OPA_W-1:0];
        DST_L:   l_r   <= acc_r[OPA_W-1:0];
        default: ;
      endcase
    end
    if (cmd.search_init) begin
      lo_r <= '0;
      hi_r <= SEARCH_HI;
    end else if (cmd.cmp) begin
      if (le) begin
        lo_r <= mid;
      end else begin
        hi_r <= mid - 15'd1;
      end
    end
    if (cmd.kk) begin
      kk_r <= kodd * kodd;
    end
    if (cmd.res) begin
      unique case (cmd.comp)
        2'd0:    rx_r <= res;
        2'd1:    ry_r <= res;
        default: rz_r <= res;
      endcase
    end
    if (cmd.out_load) begin
      deg_r <= cmd.out_degen;
      tx_r  <= cmd.out_degen ? ONE_Q14 : rx_r;
      ty_r  <= cmd.out_degen ? 16'd0 : ry_r;
      tz_r  <= cmd.out_degen ? 16'd0 : rz_r;
    end
  end

  assign tangent_x  = tx_r;
  assign tangent_y  = ty_r;
  assign tangent_z  = tz_r;
  assign degenerate = deg_r;

endmodule

### src/tvu_checker.sv
module tvu_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [47:0]  out_tdata,
  input logic         out_tuser
);

  function automatic logic in_range(input logic [15:0] c);
    return ($signed(c) >= -16'sd16384) && ($signed(c) <= 16'sd16384);
  endfunction

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == {32'd0, 16'd16384})
    else $error("degenerate result is not the unit x vector");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> in_range(out_tdata[15:0]) && in_range(out_tdata[31:16])
                   && in_range(out_tdata[47:32]))
    else $error("tangent component outside unit range");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle right after reset");

endmodule

bind triangle_tangent_vector_unit tvu_checker u_tvu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

### sim/triangle_tangent_vector_unit_tb.sv
`timescale 1ns / 1ps

module triangle_tangent_vector_unit_tb;
  import tvu_pkg::*;

  typedef logic signed [383:0] big_t;

  typedef struct {
    logic [31:0] px, py, pz;
    logic [23:0] ts, tt;
    logic        first;
    logic        drain;
  } corner_t;

  typedef struct {
    logic [15:0] tx, ty, tz;
    logic        degen;
  } tangent_t;

  localparam int unsigned CYCLE_LIMIT = 4000000;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;
  logic         out_tuser;

  triangle_tangent_vector_unit u_top (.*);

  corner_t  corner_q[$];
  tangent_t tangent_q[$];
  corner_t  cur_corner;

  logic [31:0] held_pos[6];
  logic [23:0] held_tex[4];
  int unsigned held_cnt;

  int unsigned errors, cycles;
  int unsigned in_gap, out_stall;
  bit          in_taken, out_taken, no_idle, stim_done;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] unit_comp(big_t v, big_t s);
    big_t a, lhs, rhs, k;
    int lo, hi, mid;
    a = (v < 0) ? -v : v;
    a = a * 32768;
    lhs = a * a;
    lo = 0;
    hi = ONE_Q14;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      k = 2 * mid - 1;
      rhs = k * k * s;
      if (rhs <= lhs) lo = mid;
      else hi = mid - 1;
    end
    return (v < 0) ? 16'(-lo) : 16'(lo);
  endfunction

  task automatic predict_tangent(input corner_t c);
    int unsigned idx;
    big_t p[3][3], uv[3][2];
    big_t s1, t1, s2, t2, d, ex, ey, ez, v0, v1, v2, ss;
    big_t e1[3], e2[3], tp[3], bp[3];
    tangent_t r;
    idx = c.first ? 0 : held_cnt;
    if (idx > 2) idx = 0;
    if (idx < 2) begin
      held_pos[3*idx] = c.px;
      held_pos[3*idx+1] = c.py;
      held_pos[3*idx+2] = c.pz;
      held_tex[2*idx] = c.ts;
      held_tex[2*idx+1] = c.tt;
      held_cnt = idx + 1;
      return;
    end
    held_cnt = 0;
    for (int i = 0; i < 2; i++) begin
      for (int k = 0; k < 3; k++) p[i][k] = signed'(held_pos[3*i+k]);
      uv[i][0] = signed'(held_tex[2*i]);
      uv[i][1] = signed'(held_tex[2*i+1]);
    end
    p[2][0] = signed'(c.px);
    p[2][1] = signed'(c.py);
    p[2][2] = signed'(c.pz);
    uv[2][0] = signed'(c.ts);
    uv[2][1] = signed'(c.tt);
    s1 = uv[0][0] - uv[2][0];
    t1 = uv[0][1] - uv[2][1];
    s2 = uv[1][0] - uv[2][0];
    t2 = uv[1][1] - uv[2][1];
    d = s1 * t2 - s2 * t1;
    r = '{ONE_Q14, 16'd0, 16'd0, 1'b1};
    if (d != 0) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] = p[0][k] - p[2][k];
        e2[k] = p[1][k] - p[2][k];
        tp[k] = t2 * e1[k] - t1 * e2[k];
        bp[k] = s1 * e2[k] - s2 * e1[k];
      end
      ex = e1[1] * e2[2] - e1[2] * e2[1];
      ey = e1[2] * e2[0] - e1[0] * e2[2];
      ez = e1[0] * e2[1] - e1[1] * e2[0];
      if (ex != 0 || ey != 0 || ez != 0) begin
        v0 = bp[1] * ez - bp[2] * ey;
        v1 = ey * tp[2] - ez * tp[1];
        v2 = d * ex;
        ss = v0 * v0 + v1 * v1 + v2 * v2;
        if (ss != 0) r = '{unit_comp(v0, ss), unit_comp(v1, ss), unit_comp(v2, ss), 1'b0};
      end
    end
    tangent_q.insert(tangent_q.size(), r);
  endtask

  task automatic add_corner(input logic [31:0] x, y, z, input logic [23:0] s, t,
                            input logic f, input logic dr = 1'b0);
    corner_t c;
    c = '{x, y, z, s, t, f, dr};
    corner_q.insert(corner_q.size(), c);
  endtask

  function automatic logic [31:0] rnd_pos(int unsigned mode);
    case (mode)
      0: return $urandom;
      1: return 32'($urandom_range(0, 8) << 16) - 32'(4 << 16);
      default: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [23:0] rnd_tex(int unsigned mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 3) << 14);
      default: return 24'(signed'($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned pm, tm;
    add_corner(32'h0001_0000, 0, 0, 24'h01_0000, 0, 1'b0);
    add_corner(0, 32'h0001_0000, 0, 0, 24'h01_0000, 1'b0);
    add_corner(0, 0, 0, 0, 0, 1'b0);
    add_corner(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 24'h7f_ffff, 24'h80_0000, 1'b1);
    add_corner(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 24'h80_0000, 24'h7f_ffff, 1'b0);
    add_corner(32'h0000_0000, 32'h8000_0000, 32'h7fff_ffff, 24'hff_ffff, 24'h00_0000, 1'b0);
    add_corner(32'h0003_0000, 32'h0001_0000, 0, 24'h00_1234, 24'h00_5678, 1'b1);
    add_corner(32'h0005_0000, 32'h0002_0000, 0, 24'h00_1234, 24'h00_5678, 1'b0);
    add_corner(0, 32'h0004_0000, 0, 24'h00_1234, 24'h00_5678, 1'b0);
    add_corner(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 24'h01_0000, 0, 1'b1);
    add_corner(32'h0002_0000, 32'h0002_0000, 32'h0002_0000, 0, 24'h01_0000, 1'b0);
    add_corner(0, 0, 0, 0, 0, 1'b0);
    add_corner(32'h1234_5678, 32'h0, 32'h0, 24'h10_0000, 0, 1'b1);
    add_corner(32'h0, 32'h1234_5678, 32'h0, 0, 24'h10_0000, 1'b0);
    add_corner(32'h0002_0000, 0, 32'h0001_0000, 24'h00_8000, 24'h00_4000, 1'b1, 1'b1);
    add_corner(0, 32'h0002_0000, 32'h0001_0000, 24'h00_4000, 24'h00_8000, 1'b0);
    add_corner(0, 0, 32'h0003_0000, 24'hff_0000, 24'hff_0000, 1'b0);
    add_corner(32'hffff_0000, 32'hffff_0000, 0, 24'hff_ffff, 0, 1'b0);
    add_corner(32'h0001_0000, 32'hffff_0000, 0, 0, 24'hff_ffff, 1'b0);
    add_corner(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 24'h00_0001, 24'h00_0002, 1'b0);
    while (corner_q.size() < 2000) begin
      pm = $urandom_range(0, 2);
      tm = $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) begin
        add_corner(rnd_pos(pm), rnd_pos(pm), rnd_pos(pm), rnd_tex(tm), rnd_tex(tm),
                   1'($urandom), ($urandom_range(0, 99) == 0));
      end else begin
        for (int i = 0; i < 3; i++)
          add_corner(rnd_pos(pm), rnd_pos(pm), rnd_pos(pm), rnd_tex(tm), rnd_tex(tm),
                     (i == 0) ? 1'b1 : 1'b0, (i == 0) && ($urandom_range(0, 99) == 0));
      end
    end
    stim_done = 1'b1;
  end

  // reset and cycle count
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 4) rst_n <= 1'b1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // monitor
  always @(posedge clk) begin
    tangent_t exp_t;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predict_tangent(cur_corner);
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        out_taken = 1'b1;
        if (tangent_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected item: %h %b", out_tdata, out_tuser);
        end else begin
          exp_t = tangent_q.pop_front();
          if (out_tdata !== {exp_t.tz, exp_t.ty, exp_t.tx} || out_tuser !== exp_t.degen) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp %h %h %h %b got %h %h %h %b",
                       exp_t.tx, exp_t.ty, exp_t.tz, exp_t.degen,
                       out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tuser);
          end
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    logic nv;
    if (rst_n) begin
      nv = in_tvalid;
      if ($urandom_range(0, 299) == 0) no_idle = ~no_idle;
      if (in_taken) begin
        in_taken = 1'b0;
        nv = 1'b0;
        in_gap = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (!nv) begin
        if (in_gap > 0) in_gap--;
        else if (corner_q.size() > 0 &&
                 (!corner_q[0].drain || tangent_q.size() == 0)) begin
          cur_corner = corner_q.pop_front();
          in_tdata <= {cur_corner.tt, cur_corner.ts, cur_corner.pz, cur_corner.py,
                       cur_corner.px};
          in_tuser <= cur_corner.first;
          nv = 1'b1;
        end
      end
      in_tvalid <= nv;
      if (out_taken) begin
        out_taken = 1'b0;
        out_stall = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    @(posedge clk);
    wait (corner_q.size() == 0 && !in_tvalid && tangent_q.size() == 0);
    repeat (2000) @(posedge clk);
    if (errors == 0 && tangent_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
